// File: rtl/core/snc_pkg.sv
// Shared types and constants for the segment projection block.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package snc_pkg;

  // Coordinate format and register widths.
  localparam int CW      = 32;
  localparam int FB      = 16;
  localparam int FOC_W   = 16;
  localparam int SCR_W   = 14;
  localparam int CTR_W   = SCR_W - 1;
  localparam int CFG_DW  = 16;
  localparam int CFG_IW  = 2;

  // The crossing point is projected at depth 0.001, so it is scaled by 1000*f.
  localparam int SCALE_K = 1000;
  localparam int SCALE_W = FOC_W + 10;

  // Datapath widths.
  localparam int PT_W    = CW + FOC_W;
  localparam int PROD_W  = 2 * CW;
  localparam int NSUM_W  = 2 * CW + 1;
  localparam int NUM_W   = NSUM_W + SCALE_W;
  localparam int DEN_W   = CW + 1 + FB;
  localparam int QW      = CW + 3;
  localparam int RW      = (NUM_W > DEN_W + QW - 1) ? NUM_W : DEN_W + QW - 1;
  localparam int SW      = QW + 2;
  localparam int NLANE   = 4;

  // Cycles from an accepted request to its result strobe.
  localparam int LATENCY = QW + 5;

  // Register indexes.
  localparam logic [CFG_IW-1:0] CFG_FOCAL  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd2;

  // Register reset values.
  localparam logic [FOC_W-1:0] FOCAL_RST  = 16'd500;
  localparam logic [SCR_W-1:0] WIDTH_RST  = 14'd640;
  localparam logic [SCR_W-1:0] HEIGHT_RST = 14'd480;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_depth;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_depth;
  } seg_req_t;

  typedef struct packed {
    logic                 visible;
    logic signed [CW-1:0] screen_start_x;
    logic signed [CW-1:0] screen_start_y;
    logic signed [CW-1:0] screen_end_x;
    logic signed [CW-1:0] screen_end_y;
  } seg_res_t;

  // One division lane: remainder, shifted divisor, quotient so far, sign of the offset.
  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] dsh;
    logic [QW-1:0] quo;
    logic          neg;
  } lane_t;

  // What moves from cell to cell: lanes are start col, start row, end col, end row.
  typedef struct packed {
    logic                   valid;
    logic                   vis;
    lane_t [NLANE-1:0]      ln;
  } div_item_t;

endpackage

// File: rtl/core/snc_front.sv
// Front end: endpoint decode, products, crossing numerator and lane setup.
// Depends on snc_pkg; feeds the first division cell.
module snc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_take,
  input  snc_pkg::seg_req_t             in_req,
  input  logic [snc_pkg::FOC_W-1:0]     focal,
  output snc_pkg::div_item_t            div_o
);

  localparam int CW = snc_pkg::CW;

  function automatic logic [snc_pkg::CW-1:0] mag(input logic [snc_pkg::CW-1:0] v);
    mag = v[snc_pkg::CW-1] ? (~v + 1'b1) : v;
  endfunction

  // Stage 1 decode of the request.
  logic [CW-1:0] sxm, sym, szm, exm, eym, ezm;
  logic          f1, f2;
  logic [CW-1:0] bxm, bym, bzm, gxm, gym, gzm;
  logic          bxn, byn, gxn, gyn;

  always_comb begin
    sxm = mag(in_req.start_x);
    sym = mag(in_req.start_y);
    szm = mag(in_req.start_depth);
    exm = mag(in_req.end_x);
    eym = mag(in_req.end_y);
    ezm = mag(in_req.end_depth);
    f1  = !in_req.start_depth[CW-1] && (in_req.start_depth != '0);
    f2  = !in_req.end_depth[CW-1] && (in_req.end_depth != '0);
    // The behind endpoint is the end when the start is in front.
    if (f1) begin
      bxm = exm; bym = eym; bzm = ezm; bxn = in_req.end_x[CW-1]; byn = in_req.end_y[CW-1];
      gxm = sxm; gym = sym; gzm = szm; gxn = in_req.start_x[CW-1]; gyn = in_req.start_y[CW-1];
    end else begin
      bxm = sxm; bym = sym; bzm = szm; bxn = in_req.start_x[CW-1]; byn = in_req.start_y[CW-1];
      gxm = exm; gym = eym; gzm = ezm; gxn = in_req.end_x[CW-1]; gyn = in_req.end_y[CW-1];
    end
  end

  // Stage 1 registers: focal, crossing and scale products, flags and depths.
  logic                          v1_r, v2_r, v3_r, div_valid_r;
  logic                          f1_1_r, f2_1_r, f1_2_r, f2_2_r, f1_3_r, f2_3_r;
  logic [snc_pkg::PT_W-1:0]      pt1_r [snc_pkg::NLANE];
  logic [snc_pkg::PT_W-1:0]      pt2_r [snc_pkg::NLANE];
  logic [snc_pkg::PT_W-1:0]      pt3_r [snc_pkg::NLANE];
  logic [snc_pkg::NLANE-1:0]     ptn1_r, ptn2_r, ptn3_r;
  logic [CW-1:0]                 zd1_r [2];
  logic [CW-1:0]                 zd2_r [2];
  logic [CW-1:0]                 zd3_r [2];
  logic [snc_pkg::PROD_W-1:0]    pa_r [2];
  logic [snc_pkg::PROD_W-1:0]    pb_r [2];
  logic [1:0]                    an_r, cn1_r;
  logic [CW:0]                   d1_r, d2_r, d3_r;
  logic [snc_pkg::SCALE_W-1:0]   sc1_r, sc2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    f1_1_r   <= f1;
    f2_1_r   <= f2;
    pt1_r[0] <= snc_pkg::PT_W'(sxm) * snc_pkg::PT_W'(focal);
    pt1_r[1] <= snc_pkg::PT_W'(sym) * snc_pkg::PT_W'(focal);
    pt1_r[2] <= snc_pkg::PT_W'(exm) * snc_pkg::PT_W'(focal);
    pt1_r[3] <= snc_pkg::PT_W'(eym) * snc_pkg::PT_W'(focal);
    ptn1_r   <= {!in_req.end_y[CW-1], in_req.end_x[CW-1],
                 !in_req.start_y[CW-1], in_req.start_x[CW-1]};
    zd1_r[0] <= szm;
    zd1_r[1] <= ezm;
    pa_r[0]  <= snc_pkg::PROD_W'(bxm) * snc_pkg::PROD_W'(gzm);
    pb_r[0]  <= snc_pkg::PROD_W'(gxm) * snc_pkg::PROD_W'(bzm);
    pa_r[1]  <= snc_pkg::PROD_W'(bym) * snc_pkg::PROD_W'(gzm);
    pb_r[1]  <= snc_pkg::PROD_W'(gym) * snc_pkg::PROD_W'(bzm);
    an_r     <= {byn, bxn};
    cn1_r    <= {gyn, gxn};
    d1_r     <= {1'b0, gzm} + {1'b0, bzm};
    sc1_r    <= snc_pkg::SCALE_W'(focal) * snc_pkg::SCALE_W'(snc_pkg::SCALE_K);
  end

  // Stage 2: signed sum of the two crossing products, per axis.
  logic [snc_pkg::NSUM_W-1:0] n_nxt [2];
  logic [1:0]                 nn_nxt;
  logic [snc_pkg::NSUM_W-1:0] n2_r [2];
  logic [1:0]                 nn2_r, nn3_r;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (an_r[a] == cn1_r[a]) begin
        n_nxt[a]  = snc_pkg::NSUM_W'(pa_r[a]) + snc_pkg::NSUM_W'(pb_r[a]);
        nn_nxt[a] = an_r[a];
      end else if (pa_r[a] >= pb_r[a]) begin
        n_nxt[a]  = snc_pkg::NSUM_W'(pa_r[a] - pb_r[a]);
        nn_nxt[a] = an_r[a];
      end else begin
        n_nxt[a]  = snc_pkg::NSUM_W'(pb_r[a] - pa_r[a]);
        nn_nxt[a] = cn1_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    n2_r   <= n_nxt;
    nn2_r  <= nn_nxt;
    f1_2_r <= f1_1_r;
    f2_2_r <= f2_1_r;
    pt2_r  <= pt1_r;
    ptn2_r <= ptn1_r;
    zd2_r  <= zd1_r;
    d2_r   <= d1_r;
    sc2_r  <= sc1_r;
  end

  // Stage 3: numerator times scale, as low and high partial products.
  localparam int LO_W = CW + snc_pkg::SCALE_W;
  localparam int HI_W = snc_pkg::NSUM_W - CW + snc_pkg::SCALE_W;
  logic [LO_W-1:0] plo_r [2];
  logic [HI_W-1:0] phi_r [2];

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      plo_r[a] <= LO_W'(n2_r[a][CW-1:0]) * LO_W'(sc2_r);
      phi_r[a] <= HI_W'(n2_r[a][snc_pkg::NSUM_W-1:CW]) * HI_W'(sc2_r);
    end
    nn3_r  <= nn2_r;
    f1_3_r <= f1_2_r;
    f2_3_r <= f2_2_r;
    pt3_r  <= pt2_r;
    ptn3_r <= ptn2_r;
    zd3_r  <= zd2_r;
    d3_r   <= d2_r;
  end

  // Stage 4: join partial products and pick each lane's dividend and divisor.
  logic [snc_pkg::NUM_W-1:0] cnum [2];
  snc_pkg::div_item_t        div_nxt;
  snc_pkg::div_item_t        div_r;
  logic                      fe;
  logic [snc_pkg::RW-1:0]    cden;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      cnum[a] = snc_pkg::NUM_W'(plo_r[a]) + (snc_pkg::NUM_W'(phi_r[a]) << CW);
    end
    cden          = (snc_pkg::RW'(d3_r) << snc_pkg::FB) << (snc_pkg::QW - 1);
    div_nxt       = '0;
    div_nxt.valid = v3_r;
    div_nxt.vis   = f1_3_r || f2_3_r;
    fe            = 1'b0;
    for (int l = 0; l < snc_pkg::NLANE; l++) begin
      fe = (l >= 2) ? f2_3_r : f1_3_r;
      if (fe) begin
        div_nxt.ln[l].rem = snc_pkg::RW'(pt3_r[l]);
        div_nxt.ln[l].dsh = snc_pkg::RW'(zd3_r[l/2]) << (snc_pkg::QW - 1);
        div_nxt.ln[l].neg = ptn3_r[l];
      end else begin
        div_nxt.ln[l].rem = snc_pkg::RW'(cnum[l%2]);
        div_nxt.ln[l].dsh = cden;
        // Rows are mirrored, so their offset sign is inverted.
        div_nxt.ln[l].neg = (l % 2 == 1) ? !nn3_r[1] : nn3_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_valid_r <= 1'b0;
    end else begin
      div_valid_r <= div_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  always_comb begin
    div_o       = div_r;
    div_o.valid = div_valid_r;
  end

endmodule

// File: rtl/core/snc_div_cell.sv
// One cell of the division chain: a restoring step on four lanes.
// Depends on snc_pkg; cells are chained in the top level.
module snc_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  snc_pkg::div_item_t item_i,
  output snc_pkg::div_item_t item_o
);

  snc_pkg::div_item_t item_nxt;
  snc_pkg::div_item_t item_r;
  logic               valid_r;
  logic               ge;

  // Subtract the shifted divisor where it fits, record the bit, halve the divisor.
  always_comb begin
    item_nxt = item_i;
    ge       = 1'b0;
    for (int l = 0; l < snc_pkg::NLANE; l++) begin
      ge = item_i.ln[l].rem >= item_i.ln[l].dsh;
      item_nxt.ln[l].rem = ge ? (item_i.ln[l].rem - item_i.ln[l].dsh) : item_i.ln[l].rem;
      item_nxt.ln[l].dsh = item_i.ln[l].dsh >> 1;
      item_nxt.ln[l].quo = {item_i.ln[l].quo[snc_pkg::QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= item_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  always_comb begin
    item_o       = item_r;
    item_o.valid = valid_r;
  end

endmodule

// File: rtl/core/snc_back.sv
// Back end: screen centre offset, truncation toward zero and saturation.
// Depends on snc_pkg; takes the last division cell's output.
module snc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  snc_pkg::div_item_t            item_i,
  input  logic [snc_pkg::SCR_W-1:0]     scr_w,
  input  logic [snc_pkg::SCR_W-1:0]     scr_h,
  output logic                          out_valid,
  output snc_pkg::seg_res_t             out_result
);

  localparam int SW = snc_pkg::SW;
  localparam int CW = snc_pkg::CW;
  localparam logic signed [SW-1:0] SMAX = $signed({{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}});
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  logic signed [SW-1:0]   s   [snc_pkg::NLANE];
  logic signed [SW-1:0]   qs;
  logic [snc_pkg::CTR_W-1:0] ctr;
  logic [CW-1:0]          val [snc_pkg::NLANE];
  snc_pkg::seg_res_t      res_nxt;
  snc_pkg::seg_res_t      res_r;
  logic                   out_valid_r;

  // Offset from the centre, fix the truncation direction, then clamp.
  always_comb begin
    qs  = '0;
    ctr = '0;
    for (int l = 0; l < snc_pkg::NLANE; l++) begin
      ctr  = (l % 2 == 1) ? scr_h[snc_pkg::SCR_W-1:1] : scr_w[snc_pkg::SCR_W-1:1];
      qs   = $signed({2'b00, item_i.ln[l].quo});
      s[l] = $signed({{(SW-snc_pkg::CTR_W){1'b0}}, ctr}) + (item_i.ln[l].neg ? -qs : qs);
      if (item_i.ln[l].rem != '0) begin
        if (!item_i.ln[l].neg && s[l] < 0) begin
          s[l] = s[l] + $signed({{(SW-1){1'b0}}, 1'b1});
        end else if (item_i.ln[l].neg && s[l] > 0) begin
          s[l] = s[l] - $signed({{(SW-1){1'b0}}, 1'b1});
        end
      end
      if (s[l] > SMAX) begin
        val[l] = SMAX[CW-1:0];
      end else if (s[l] < SMIN) begin
        val[l] = SMIN[CW-1:0];
      end else begin
        val[l] = s[l][CW-1:0];
      end
      if (!item_i.vis) begin
        val[l] = '0;
      end
    end
    res_nxt.visible        = item_i.vis;
    res_nxt.screen_start_x = $signed(val[0]);
    res_nxt.screen_start_y = $signed(val[1]);
    res_nxt.screen_end_x   = $signed(val[2]);
    res_nxt.screen_end_y   = $signed(val[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= item_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = res_r;

endmodule

// File: rtl/core/segment_near_clip_project.sv
// Segment projection with near-plane clipping: a new request can be taken on every
// cycle while busy is low, and its result appears on out_result with out_valid high
// for one cycle, after the front end, a chain of 35 division cells (one quotient bit
// per cell) and the back end. The receiver cannot stall, so results must be captured
// when out_valid is high. busy is high only during reset.
// Configuration must be written only when no request is in flight.
// Depends on snc_pkg, snc_front, snc_div_cell and snc_back.
module segment_near_clip_project (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  snc_pkg::seg_req_t              in_req,
  input  logic                           cfg_we,
  input  logic [snc_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [snc_pkg::CFG_DW-1:0]     cfg_wdata,
  output logic                           out_valid,
  output snc_pkg::seg_res_t              out_result
);

  logic [snc_pkg::FOC_W-1:0] focal_r;
  logic [snc_pkg::SCR_W-1:0] width_r;
  logic [snc_pkg::SCR_W-1:0] height_r;
  logic                      busy_r;
  logic                      in_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r  <= snc_pkg::FOCAL_RST;
      width_r  <= snc_pkg::WIDTH_RST;
      height_r <= snc_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        snc_pkg::CFG_FOCAL:  focal_r  <= cfg_wdata;
        snc_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[snc_pkg::SCR_W-1:0];
        snc_pkg::CFG_HEIGHT: height_r <= cfg_wdata[snc_pkg::SCR_W-1:0];
        default: ;
      endcase
    end
  end

  // Busy only while held in reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy    = busy_r;
  assign in_take = start && !busy_r;

  snc_pkg::div_item_t chain [snc_pkg::QW+1];

  snc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_take(in_take),
    .in_req (in_req),
    .focal  (focal_r),
    .div_o  (chain[0])
  );

  // Division chain, most significant quotient bit first.
  for (genvar i = 0; i < snc_pkg::QW; i++) begin : g_cell
    snc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .item_i(chain[i]),
      .item_o(chain[i+1])
    );
  end

  snc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_i    (chain[snc_pkg::QW]),
    .scr_w     (width_r),
    .scr_h     (height_r),
    .out_valid (out_valid),
    .out_result(out_result)
  );

endmodule

// File: rtl/core/snc_checker.sv
// Port-level checks for the segment projection block, bound to its top level.
// Depends on snc_pkg and segment_near_clip_project.
module snc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input snc_pkg::seg_req_t              in_req,
  input logic                           cfg_we,
  input logic [snc_pkg::CFG_IW-1:0]     cfg_index,
  input logic [snc_pkg::CFG_DW-1:0]     cfg_wdata,
  input logic                           out_valid,
  input snc_pkg::seg_res_t              out_result
);

  localparam int CW = snc_pkg::CW;

  // Reset raises busy and clears the result strobe.
  a_reset: assert property (@(posedge clk) !rst_n |=> busy && !out_valid)
    else $error("reset did not raise busy or clear out_valid");

  // Every result comes from a request accepted a fixed time earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, snc_pkg::LATENCY))
    else $error("result without a matching request");

  // Visibility follows the depths of that request.
  a_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result.visible ==
      $past((!in_req.start_depth[CW-1] && in_req.start_depth != '0) ||
            (!in_req.end_depth[CW-1] && in_req.end_depth != '0), snc_pkg::LATENCY))
    else $error("visible flag does not match request depths");

  // A hidden segment reports zero coordinates.
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result.visible |->
      out_result.screen_start_x == '0 && out_result.screen_start_y == '0 &&
      out_result.screen_end_x == '0 && out_result.screen_end_y == '0)
    else $error("hidden segment with nonzero coordinates");

endmodule

bind segment_near_clip_project snc_checker u_snc_checker (.*);
